/* design/lr3d_pkg.sv */
// ----------------------------------------------------------------------------
// lr3d_pkg: shared types for the 3D line rasterizer
// Transaction payload structs, axis codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lr3d_pkg;

  // Width of every coordinate field on the ports.
  localparam int FIELD_BITS = 6;

  typedef logic [FIELD_BITS-1:0] coord_field_t;

  // One line request transaction.
  typedef struct packed {
    coord_field_t start_x;
    coord_field_t start_y;
    coord_field_t start_z;
    coord_field_t end_x;
    coord_field_t end_y;
    coord_field_t end_z;
  } line_req_t;

  // One voxel result transaction.
  typedef struct packed {
    coord_field_t point_x;
    coord_field_t point_y;
    coord_field_t point_z;
    logic         last_point;
  } voxel_t;

  // Axis codes, also used as indexes into per-axis vectors.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } state_t;

endpackage

/* design/line_rasterizer_3d_top.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_3d_top: 3D Bresenham line rasterizer
// The sequencer goes from idle, where start is taken, to a load state that loads
// the stepper, then to a run state that gives one voxel per cycle up to and
// including the end point; a new line is taken only once back in idle.
// Reset returns the sequencer to idle; the receiver cannot stall results.
// Each voxel is a one-cycle transaction on result, marked by result_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer_3d_top #(
  parameter int COORD_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lr3d_pkg::line_req_t req,
  output logic                result_valid,
  output lr3d_pkg::voxel_t    result
);
  import lr3d_pkg::*;

  state_t state;
  state_t state_next;

  logic                          accept;
  logic                          load_step;
  logic                          advance;
  logic [2:0][COORD_BITS-1:0]    origin;
  logic [2:0]                    dir_up;
  axis_t                         major;
  axis_t                         minor1;
  axis_t                         minor2;
  logic [COORD_BITS-1:0]         length;
  logic [COORD_BITS:0]           inc1;
  logic [COORD_BITS:0]           inc2;
  logic [COORD_BITS:0]           dec;
  logic signed [COORD_BITS+2:0]  err1_init;
  logic signed [COORD_BITS+2:0]  err2_init;
  logic [2:0][COORD_BITS-1:0]    cur;
  logic                          last;

  // Setup stage captures the line plan on an accepted transaction.
  lr3d_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .clk       (clk),
    .load      (accept),
    .req       (req),
    .origin    (origin),
    .dir_up    (dir_up),
    .major     (major),
    .minor1    (minor1),
    .minor2    (minor2),
    .length    (length),
    .inc1      (inc1),
    .inc2      (inc2),
    .dec       (dec),
    .err1_init (err1_init),
    .err2_init (err2_init)
  );

  // Step unit walks the line one voxel per cycle.
  lr3d_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk       (clk),
    .load      (load_step),
    .advance   (advance),
    .origin    (origin),
    .dir_up    (dir_up),
    .major     (major),
    .minor1    (minor1),
    .minor2    (minor2),
    .length    (length),
    .inc1      (inc1),
    .inc2      (inc2),
    .dec       (dec),
    .err1_init (err1_init),
    .err2_init (err2_init),
    .cur       (cur),
    .last      (last)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next   = state;
    busy         = 1'b1;
    accept       = 1'b0;
    load_step    = 1'b0;
    advance      = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
        if (start) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        load_step  = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        result_valid = 1'b1;
        advance      = 1'b1;
        if (last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result transaction comes straight from the step unit registers.
  assign result.point_x    = coord_field_t'(cur[AXIS_X]);
  assign result.point_y    = coord_field_t'(cur[AXIS_Y]);
  assign result.point_z    = coord_field_t'(cur[AXIS_Z]);
  assign result.last_point = last;

endmodule

/* design/lr3d_setup.sv */
// ----------------------------------------------------------------------------
// lr3d_setup: line setup stage
// Registers the start point, per-axis directions, the driving axis and the
// initial error terms and increments for one line request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr3d_setup #(
  parameter int COORD_BITS = 6
) (
  input  logic                           clk,
  input  logic                           load,
  input  lr3d_pkg::line_req_t            req,
  output logic [2:0][COORD_BITS-1:0]     origin,
  output logic [2:0]                     dir_up,
  output lr3d_pkg::axis_t                major,
  output lr3d_pkg::axis_t                minor1,
  output lr3d_pkg::axis_t                minor2,
  output logic [COORD_BITS-1:0]          length,
  output logic [COORD_BITS:0]            inc1,
  output logic [COORD_BITS:0]            inc2,
  output logic [COORD_BITS:0]            dec,
  output logic signed [COORD_BITS+2:0]   err1_init,
  output logic signed [COORD_BITS+2:0]   err2_init
);
  import lr3d_pkg::*;

  localparam int EW = COORD_BITS + 3;

  logic [2:0][COORD_BITS-1:0] src;
  logic [2:0][COORD_BITS-1:0] dst;
  logic [2:0][COORD_BITS-1:0] delta;
  logic [2:0]                 up;
  axis_t                      major_c;
  axis_t                      minor1_c;
  axis_t                      minor2_c;
  logic [COORD_BITS-1:0]      d_major;
  logic [COORD_BITS-1:0]      d_minor1;
  logic [COORD_BITS-1:0]      d_minor2;

  // Bits above the grid width are ignored.
  assign src[0] = req.start_x[COORD_BITS-1:0];
  assign src[1] = req.start_y[COORD_BITS-1:0];
  assign src[2] = req.start_z[COORD_BITS-1:0];
  assign dst[0] = req.end_x[COORD_BITS-1:0];
  assign dst[1] = req.end_y[COORD_BITS-1:0];
  assign dst[2] = req.end_z[COORD_BITS-1:0];

  // Absolute delta and direction of each axis.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      up[a]    = dst[a] > src[a];
      delta[a] = up[a] ? (dst[a] - src[a]) : (src[a] - dst[a]);
    end
  end

  // Driving axis: x wins ties, then y over z.
  always_comb begin
    if (delta[0] >= delta[1] && delta[0] >= delta[2]) begin
      major_c  = AXIS_X;
      minor1_c = AXIS_Y;
      minor2_c = AXIS_Z;
      d_major  = delta[0];
      d_minor1 = delta[1];
      d_minor2 = delta[2];
    end else if (delta[1] >= delta[2]) begin
      major_c  = AXIS_Y;
      minor1_c = AXIS_X;
      minor2_c = AXIS_Z;
      d_major  = delta[1];
      d_minor1 = delta[0];
      d_minor2 = delta[2];
    end else begin
      major_c  = AXIS_Z;
      minor1_c = AXIS_Y;
      minor2_c = AXIS_X;
      d_major  = delta[2];
      d_minor1 = delta[1];
      d_minor2 = delta[0];
    end
  end

  // Capture the line plan when a request is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      origin    <= src;
      dir_up    <= up;
      major     <= major_c;
      minor1    <= minor1_c;
      minor2    <= minor2_c;
      length    <= d_major;
      inc1      <= {d_minor1, 1'b0};
      inc2      <= {d_minor2, 1'b0};
      dec       <= {d_major, 1'b0};
      err1_init <= $signed({2'b00, d_minor1, 1'b0}) - $signed(EW'(d_major));
      err2_init <= $signed({2'b00, d_minor2, 1'b0}) - $signed(EW'(d_major));
    end
  end

endmodule

/* design/lr3d_stepper.sv */
// ----------------------------------------------------------------------------
// lr3d_stepper: voxel step unit
// Holds the current voxel and both error terms, and advances the line by one
// voxel per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr3d_stepper #(
  parameter int COORD_BITS = 6
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           advance,
  input  logic [2:0][COORD_BITS-1:0]     origin,
  input  logic [2:0]                     dir_up,
  input  lr3d_pkg::axis_t                major,
  input  lr3d_pkg::axis_t                minor1,
  input  lr3d_pkg::axis_t                minor2,
  input  logic [COORD_BITS-1:0]          length,
  input  logic [COORD_BITS:0]            inc1,
  input  logic [COORD_BITS:0]            inc2,
  input  logic [COORD_BITS:0]            dec,
  input  logic signed [COORD_BITS+2:0]   err1_init,
  input  logic signed [COORD_BITS+2:0]   err2_init,
  output logic [2:0][COORD_BITS-1:0]     cur,
  output logic                           last
);
  import lr3d_pkg::*;

  localparam int EW = COORD_BITS + 3;

  logic signed [EW-1:0]        err1;
  logic signed [EW-1:0]        err2;
  logic [COORD_BITS-1:0]       count;
  logic signed [EW-1:0]        err1_next;
  logic signed [EW-1:0]        err2_next;
  logic [2:0][COORD_BITS-1:0]  cur_next;
  logic                        take1;
  logic                        take2;
  logic [2:0]                  step;

  // A minor axis steps when its error term is not negative.
  assign take1 = !err1[EW-1];
  assign take2 = !err2[EW-1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      step[a] = (major == axis_t'(2'(a))) ||
                (take1 && minor1 == axis_t'(2'(a))) ||
                (take2 && minor2 == axis_t'(2'(a)));
      if (step[a]) begin
        cur_next[a] = dir_up[a] ? (cur[a] + COORD_BITS'(1)) : (cur[a] - COORD_BITS'(1));
      end else begin
        cur_next[a] = cur[a];
      end
    end
  end

  // Error update: pay back twice the major delta on a step, then add the increment.
  always_comb begin
    err1_next = err1 + $signed(EW'(inc1)) - (take1 ? $signed(EW'(dec)) : '0);
    err2_next = err2 + $signed(EW'(inc2)) - (take2 ? $signed(EW'(dec)) : '0);
  end

  // The current voxel is the last one once the count reaches the major delta.
  assign last = (count == length);

  always_ff @(posedge clk) begin
    if (load) begin
      cur   <= origin;
      err1  <= err1_init;
      err2  <= err2_init;
      count <= '0;
    end else if (advance) begin
      cur   <= cur_next;
      err1  <= err1_next;
      err2  <= err2_next;
      count <= count + COORD_BITS'(1);
    end
  end

endmodule
